@@ design/drp_pkg.sv @@
// ----------------------------------------------------------------------------
// drp_pkg
// Shared widths, reset values, codes, state types and control structs for
// the dual-rate pacer with rate meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drp_pkg;

  localparam int unsigned TIME_BITS_DEF  = 32;
  localparam int unsigned RATE_FRAC_DEF  = 8;

  localparam int unsigned DATA_W  = 32;   // periods, intervals, rates, counts
  localparam int unsigned WIN_W   = 40;   // window accumulator
  localparam int unsigned TOTAL_W = 48;   // running tick total
  localparam int unsigned PROD_W  = 52;   // count times one million
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [19:0]        US_PER_S = 20'd1000000;
  localparam logic [DATA_W-1:0]  MAX32    = '1;
  localparam logic [WIN_W-1:0]   MAX40    = '1;

  localparam logic [DATA_W-1:0] FRAME_PERIOD_RST = 32'd16667;
  localparam logic [DATA_W-1:0] TICK_PERIOD_RST  = 32'd50000;
  localparam logic [DATA_W-1:0] SAMPLE_RST       = 32'd1000000;
  localparam logic [DATA_W-1:0] GAP_RST          = 32'd1000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_PERIOD    = 2'd0,
    CFG_TICK_PERIOD     = 2'd1,
    CFG_SAMPLE_INTERVAL = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_STEP,
    SEQ_F_LAUNCH,
    SEQ_F_WAIT,
    SEQ_T_LAUNCH,
    SEQ_T_WAIT,
    SEQ_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_NORM,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef enum logic {
    CH_FRAME,
    CH_TICK
  } ch_sel_t;

  typedef struct packed {
    logic    in_ready;
    logic    step;
    logic    div_start;
    ch_sel_t div_sel;
    logic    rate_load_f;
    logic    rate_load_t;
    logic    out_load;
  } seq_ctl_t;

  typedef struct packed {
    logic in_fire;
    logic pend_f;
    logic pend_t;
    logic div_done;
    logic out_free;
  } seq_stat_t;

endpackage

`default_nettype wire

@@ design/drp_if.sv @@
// ----------------------------------------------------------------------------
// drp_if
// Handshake channels of the pacer: timestamp input, result output and
// configuration write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface drp_in_if import drp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] now_us;

  modport source (output valid, output now_us, input ready);
  modport sink   (input valid, input now_us, output ready);
endinterface

interface drp_out_if import drp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               frame_due;
  logic               tick_due;
  logic [DATA_W-1:0]  frame_interval_us;
  logic [DATA_W-1:0]  tick_interval_us;
  logic [TOTAL_W-1:0] ticks_total;
  logic [DATA_W-1:0]  frame_rate_q8;
  logic [DATA_W-1:0]  tick_rate_q8;

  modport source (output valid, output frame_due, output tick_due,
                  output frame_interval_us, output tick_interval_us,
                  output ticks_total, output frame_rate_q8, output tick_rate_q8,
                  input ready);
  modport sink   (input valid, input frame_due, input tick_due,
                  input frame_interval_us, input tick_interval_us,
                  input ticks_total, input frame_rate_q8, input tick_rate_q8,
                  output ready);
endinterface

interface drp_cfg_if import drp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/drp_chan.sv @@
// ----------------------------------------------------------------------------
// drp_chan
// One pacing channel: elapsed-time check, interval capture, saturating
// window accumulator and event count, and the last measured rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drp_chan import drp_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire logic [DATA_W-1:0]    period,
  input  wire logic [DATA_W-1:0]    sample_interval,
  input  wire logic                 step,
  input  wire logic                 rate_load,
  input  wire logic [DATA_W-1:0]    rate_value,
  output logic                      due,
  output logic                      pend,
  output logic [DATA_W-1:0]         gap,
  output logic [DATA_W-1:0]         rate,
  output logic [WIN_W-1:0]          win_time,
  output logic [DATA_W-1:0]         win_count
);

  localparam int unsigned EW = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;

  logic [TIME_BITS-1:0] last_time;
  logic [TIME_BITS-1:0] elapsed;
  logic [EW-1:0]        elapsed_x;
  logic                 fire;
  logic [DATA_W-1:0]    gap_next;
  logic [WIN_W:0]       win_sum;
  logic [WIN_W-1:0]     win_time_next;
  logic [DATA_W-1:0]    win_count_next;

  always_comb begin
    elapsed        = now - last_time;
    elapsed_x      = EW'(elapsed);
    fire           = !(elapsed_x < EW'(period));
    gap_next       = (elapsed_x > EW'(MAX32)) ? MAX32 : elapsed_x[DATA_W-1:0];
    win_sum        = (WIN_W+1)'(win_time) + (WIN_W+1)'(gap_next);
    win_time_next  = win_sum[WIN_W] ? MAX40 : win_sum[WIN_W-1:0];
    win_count_next = (win_count == MAX32) ? win_count : win_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      gap       <= GAP_RST;
      win_time  <= '0;
      win_count <= '0;
      rate      <= '0;
      pend      <= 1'b0;
      due       <= 1'b0;
    end else if (step) begin
      due <= fire;
      if (fire) begin
        last_time <= now;
        gap       <= gap_next;
        win_time  <= win_time_next;
        win_count <= win_count_next;
        pend      <= win_time_next > WIN_W'(sample_interval);
      end
    end else if (rate_load) begin
      // window closes once its rate is in
      rate      <= rate_value;
      win_time  <= '0;
      win_count <= '0;
      pend      <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ design/drp_div.sv @@
// ----------------------------------------------------------------------------
// drp_div
// Shared rate unit: count * 10^6 * 2^F / window, one restoring-division bit
// per cycle, result saturated to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drp_div import drp_pkg::*; #(
  parameter int unsigned RATE_FRACTION_BITS = RATE_FRAC_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] count,
  input  wire logic [WIN_W-1:0]  window,
  output logic                   done,
  output logic [DATA_W-1:0]      quot
);

  localparam int unsigned NUM_W   = PROD_W + RATE_FRACTION_BITS;
  localparam int unsigned HI_W    = NUM_W - DATA_W;
  localparam int unsigned STEP_W  = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  div_state_t state, state_next;

  logic [DATA_W-1:0] count_q;
  logic [WIN_W-1:0]  w_q;
  logic [PROD_W-1:0] prod;
  logic [WIN_W-1:0]  rem;
  logic [DATA_W-1:0] lo;
  logic [STEP_W-1:0] step_cnt;

  logic [NUM_W-1:0]  num;
  logic [HI_W-1:0]   hi;
  logic              sat;
  logic [WIN_W:0]    trial;
  logic [WIN_W-1:0]  diff;
  logic              ge;

  always_comb begin
    num   = NUM_W'(prod) << RATE_FRACTION_BITS;
    hi    = num[NUM_W-1:DATA_W];
    sat   = !((WIN_W+1)'(hi) < {1'b0, w_q});
    trial = {rem, lo[DATA_W-1]};
    diff  = trial[WIN_W-1:0] - w_q;
    ge    = !(trial < {1'b0, w_q});
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_MUL;
      DIV_MUL:  state_next = DIV_NORM;
      DIV_NORM: state_next = sat ? DIV_DONE : DIV_RUN;
      DIV_RUN:  if (step_cnt == LAST_STEP) state_next = DIV_DONE;
      DIV_DONE: state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      DIV_DONE: done = 1'b1;
      default:  done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          count_q <= count;
          w_q     <= window;
        end
      end
      DIV_MUL: begin
        prod <= PROD_W'(count_q) * PROD_W'(US_PER_S);
      end
      DIV_NORM: begin
        // quotient of 2^32 or more saturates; else top part seeds remainder
        if (sat) begin
          quot <= MAX32;
        end else begin
          rem      <= WIN_W'(hi);
          lo       <= num[DATA_W-1:0];
          quot     <= '0;
          step_cnt <= '0;
        end
      end
      DIV_RUN: begin
        rem      <= ge ? diff : trial[WIN_W-1:0];
        quot     <= {quot[DATA_W-2:0], ge};
        lo       <= {lo[DATA_W-2:0], 1'b0};
        step_cnt <= step_cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/drp_seq.sv @@
// ----------------------------------------------------------------------------
// drp_seq
// Item sequencer: step both channels, run the rate unit for each channel
// whose window closed, then hand the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drp_seq import drp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire seq_stat_t stat,
  output seq_ctl_t       ctl
);

  seq_state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE:     if (stat.in_fire) state_next = SEQ_STEP;
      SEQ_STEP:     state_next = SEQ_F_LAUNCH;
      SEQ_F_LAUNCH: state_next = stat.pend_f ? SEQ_F_WAIT : SEQ_T_LAUNCH;
      SEQ_F_WAIT:   if (stat.div_done) state_next = SEQ_T_LAUNCH;
      SEQ_T_LAUNCH: state_next = stat.pend_t ? SEQ_T_WAIT : SEQ_DONE;
      SEQ_T_WAIT:   if (stat.div_done) state_next = SEQ_DONE;
      SEQ_DONE:     if (stat.out_free) state_next = SEQ_IDLE;
      default:      state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state)
      SEQ_IDLE:     ctl.in_ready = 1'b1;
      SEQ_STEP:     ctl.step = 1'b1;
      SEQ_F_LAUNCH: begin
        ctl.div_sel   = CH_FRAME;
        ctl.div_start = stat.pend_f;
      end
      SEQ_F_WAIT:   ctl.rate_load_f = stat.div_done;
      SEQ_T_LAUNCH: begin
        ctl.div_sel   = CH_TICK;
        ctl.div_start = stat.pend_t;
      end
      SEQ_T_WAIT:   ctl.rate_load_t = stat.div_done;
      SEQ_DONE:     ctl.out_load = stat.out_free;
      default:      ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ design/dual_rate_pacer_with_rate_meter.sv @@
// ----------------------------------------------------------------------------
// dual_rate_pacer_with_rate_meter
// Frame and tick pacer on a microsecond timestamp, with interval capture,
// tick total and windowed rate measurement in Hz (fixed point).
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      carries
//   pace_in   in    valid/ready    now_us
//   pace_out  out   valid/ready    frame_due, tick_due, intervals, ticks_total,
//                                  frame_rate_q8, tick_rate_q8
//   cfg       in    valid/ready    index, data (0 frame period, 1 tick period,
//                                  2 sample interval); always ready
//
// For each channel whose window closes, an item also runs the shared rate
// unit (multiply, saturation check, 32 division steps and a done state);
// when that rate saturates, the division steps are skipped.
// Synchronous active-high reset loads the default periods and intervals and
// clears the rest of the channel state; no clearing pass is needed.
// A result waits in the output register while the next item is taken;
// the sequencer holds only at its final step until that register frees up.
`timescale 1ns / 1ps
`default_nettype none

module dual_rate_pacer_with_rate_meter import drp_pkg::*; #(
  parameter int unsigned TIME_BITS          = TIME_BITS_DEF,
  parameter int unsigned RATE_FRACTION_BITS = RATE_FRAC_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  drp_in_if.sink    pace_in,
  drp_out_if.source pace_out,
  drp_cfg_if.sink   cfg
);

  // Configuration registers
  logic [DATA_W-1:0] frame_period;
  logic [DATA_W-1:0] tick_period;
  logic [DATA_W-1:0] sample_interval;

  // Item and running state
  logic [TIME_BITS-1:0] now_q;
  logic [TOTAL_W-1:0]   tick_total;
  logic [TOTAL_W-1:0]   tick_total_next;

  // Output register
  logic out_valid;

  seq_ctl_t  ctl;
  seq_stat_t stat;

  // Channel views
  logic              f_due, f_pend;
  logic [DATA_W-1:0] f_gap, f_rate, f_cnt;
  logic [WIN_W-1:0]  f_win;
  logic              t_due, t_pend;
  logic [DATA_W-1:0] t_gap, t_rate, t_cnt;
  logic [WIN_W-1:0]  t_win;

  // Rate unit
  logic              div_done;
  logic [DATA_W-1:0] div_quot;
  logic [DATA_W-1:0] div_count;
  logic [WIN_W-1:0]  div_window;

  assign cfg.ready     = 1'b1;
  assign pace_in.ready = ctl.in_ready;

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period    <= FRAME_PERIOD_RST;
      tick_period     <= TICK_PERIOD_RST;
      sample_interval <= SAMPLE_RST;
    end else if (cfg.valid) begin
      case (cfg_idx_t'(cfg.index))
        CFG_FRAME_PERIOD:    frame_period    <= cfg.data;
        CFG_TICK_PERIOD:     tick_period     <= cfg.data;
        CFG_SAMPLE_INTERVAL: sample_interval <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Hold the timestamp for the duration of the item
  always_ff @(posedge clk) begin
    if (pace_in.valid && ctl.in_ready) begin
      now_q <= TIME_BITS'(pace_in.now_us);
    end
  end

  // Advance the wrapping tick total on a tick event; the tick flag of the
  // item stays put from its step until the result is loaded
  assign tick_total_next = tick_total + TOTAL_W'(t_due);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_total <= '0;
    end else if (ctl.out_load) begin
      tick_total <= tick_total_next;
    end
  end

  always_comb begin
    stat.in_fire  = pace_in.valid && ctl.in_ready;
    stat.pend_f   = f_pend;
    stat.pend_t   = t_pend;
    stat.div_done = div_done;
    stat.out_free = !out_valid || pace_out.ready;
  end

  // Only the operands at launch matter; the rate unit captures them
  assign div_count  = (ctl.div_sel == CH_TICK) ? t_cnt : f_cnt;
  assign div_window = (ctl.div_sel == CH_TICK) ? t_win : f_win;

  drp_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  drp_chan #(.TIME_BITS(TIME_BITS)) u_frame (
    .clk             (clk),
    .rst             (rst),
    .now             (now_q),
    .period          (frame_period),
    .sample_interval (sample_interval),
    .step            (ctl.step),
    .rate_load       (ctl.rate_load_f),
    .rate_value      (div_quot),
    .due             (f_due),
    .pend            (f_pend),
    .gap             (f_gap),
    .rate            (f_rate),
    .win_time        (f_win),
    .win_count       (f_cnt)
  );

  drp_chan #(.TIME_BITS(TIME_BITS)) u_tick (
    .clk             (clk),
    .rst             (rst),
    .now             (now_q),
    .period          (tick_period),
    .sample_interval (sample_interval),
    .step            (ctl.step),
    .rate_load       (ctl.rate_load_t),
    .rate_value      (div_quot),
    .due             (t_due),
    .pend            (t_pend),
    .gap             (t_gap),
    .rate            (t_rate),
    .win_time        (t_win),
    .win_count       (t_cnt)
  );

  drp_div #(.RATE_FRACTION_BITS(RATE_FRACTION_BITS)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.div_start),
    .count  (div_count),
    .window (div_window),
    .done   (div_done),
    .quot   (div_quot)
  );

  // Output register: load on the final step, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (pace_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      pace_out.frame_due         <= f_due;
      pace_out.tick_due          <= t_due;
      pace_out.frame_interval_us <= f_gap;
      pace_out.tick_interval_us  <= t_gap;
      pace_out.ticks_total       <= tick_total_next;
      pace_out.frame_rate_q8     <= f_rate;
      pace_out.tick_rate_q8      <= t_rate;
    end
  end

  assign pace_out.valid = out_valid;

endmodule

`default_nettype wire

@@ tb/pace_checker.sv @@
// ----------------------------------------------------------------------------
// pace_checker
// Watches the timestamp, result and register channels of the pacer. It keeps
// its own copy of the pacer state, predicts one result per accepted
// timestamp and compares every field of each accepted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pace_checker import drp_pkg::*; (
  input  logic clk,
  input  logic rst,
  drp_in_if    pace_in,
  drp_out_if   pace_out,
  drp_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic               frame_due;
    logic               tick_due;
    logic [DATA_W-1:0]  frame_interval_us;
    logic [DATA_W-1:0]  tick_interval_us;
    logic [TOTAL_W-1:0] ticks_total;
    logic [DATA_W-1:0]  frame_rate_q8;
    logic [DATA_W-1:0]  tick_rate_q8;
  } pace_result_t;

  typedef struct {
    logic [DATA_W-1:0] last_time;
    logic [DATA_W-1:0] gap;
    logic [WIN_W-1:0]  win_time;
    logic [DATA_W-1:0] win_count;
    logic [DATA_W-1:0] rate;
  } lane_t;

  logic [DATA_W-1:0]  frame_period;
  logic [DATA_W-1:0]  tick_period;
  logic [DATA_W-1:0]  sample_interval;
  lane_t              lanes [2];
  logic [TOTAL_W-1:0] tick_count;
  pace_result_t       pace_results_q [$];
  int                 result_idx;

  // Hz with fraction bits: count * 10^6 * 2^F / window, truncated, saturated.
  function automatic logic [DATA_W-1:0] hz_q8(logic [DATA_W-1:0] count,
                                              logic [WIN_W-1:0] window);
    logic [63:0] scaled;
    scaled = (64'(count) * 64'(US_PER_S)) << RATE_FRAC_DEF;
    scaled = scaled / 64'(window);
    return (scaled > 64'(MAX32)) ? MAX32 : scaled[DATA_W-1:0];
  endfunction

  // Advance one channel; returns 1 when it fires on this timestamp.
  function automatic logic lane_fires(ch_sel_t ch, logic [DATA_W-1:0] now,
                                      logic [DATA_W-1:0] period);
    logic [DATA_W-1:0] elapsed;
    logic [WIN_W:0]    sum;
    elapsed = now - lanes[ch].last_time;
    if (elapsed < period) return 1'b0;
    lanes[ch].gap       = elapsed;
    lanes[ch].last_time = now;
    sum = lanes[ch].win_time + elapsed;
    lanes[ch].win_time = (sum > MAX40) ? MAX40 : sum[WIN_W-1:0];
    if (lanes[ch].win_count != MAX32) lanes[ch].win_count = lanes[ch].win_count + 1'b1;
    if (lanes[ch].win_time > sample_interval) begin
      lanes[ch].rate      = hz_q8(lanes[ch].win_count, lanes[ch].win_time);
      lanes[ch].win_time  = '0;
      lanes[ch].win_count = '0;
    end
    return 1'b1;
  endfunction

  function automatic pace_result_t predict_pace(logic [DATA_W-1:0] now);
    pace_result_t r;
    r.frame_due = lane_fires(CH_FRAME, now, frame_period);
    r.tick_due  = lane_fires(CH_TICK, now, tick_period);
    if (r.tick_due) tick_count = tick_count + 1'b1;
    r.frame_interval_us = lanes[CH_FRAME].gap;
    r.tick_interval_us  = lanes[CH_TICK].gap;
    r.ticks_total       = tick_count;
    r.frame_rate_q8     = lanes[CH_FRAME].rate;
    r.tick_rate_q8      = lanes[CH_TICK].rate;
    return r;
  endfunction

  function automatic void check_field(string what, logic [TOTAL_W-1:0] want,
                                      logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %h, got %h", result_idx, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    pace_result_t want;
    if (rst) begin
      frame_period    = FRAME_PERIOD_RST;
      tick_period     = TICK_PERIOD_RST;
      sample_interval = SAMPLE_RST;
      foreach (lanes[i]) begin
        lanes[i].last_time = '0;
        lanes[i].gap       = GAP_RST;
        lanes[i].win_time  = '0;
        lanes[i].win_count = '0;
        lanes[i].rate      = '0;
      end
      tick_count = '0;
      pace_results_q.delete();
      result_idx  = 0;
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_FRAME_PERIOD:    frame_period    = cfg.data;
          CFG_TICK_PERIOD:     tick_period     = cfg.data;
          CFG_SAMPLE_INTERVAL: sample_interval = cfg.data;
          default: ;  // unused index: drop the write
        endcase
      end
      // Retire a result before taking a new timestamp, so a result that
      // overtakes its own timestamp is flagged.
      if (pace_out.valid && pace_out.ready) begin
        if (pace_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: arrived with nothing expected", result_idx);
        end else begin
          want = pace_results_q.pop_front();
          check_field("frame_due", want.frame_due, pace_out.frame_due);
          check_field("tick_due", want.tick_due, pace_out.tick_due);
          check_field("frame_interval_us", want.frame_interval_us,
                      pace_out.frame_interval_us);
          check_field("tick_interval_us", want.tick_interval_us,
                      pace_out.tick_interval_us);
          check_field("ticks_total", want.ticks_total, pace_out.ticks_total);
          check_field("frame_rate_q8", want.frame_rate_q8, pace_out.frame_rate_q8);
          check_field("tick_rate_q8", want.tick_rate_q8, pace_out.tick_rate_q8);
        end
        result_idx++;
      end
      if (pace_in.valid && pace_in.ready)
        pace_results_q.push_back(predict_pace(pace_in.now_us));
      outstanding = pace_results_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the dual-rate pacer. Drives timestamps and
// register writes with random idling on both sides, while pace_checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import drp_pkg::*;

  // Index past the register list; the pacer must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  // Longest run of cycles with no handshake on any channel. It allows for
  // the longest item plus random output stalls.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES          = 15;
  localparam int STAMPS_PER_PHASE = 36;

  logic clk;
  logic rst;
  logic calm;  // high: neither side idles
  int   mismatches;
  int   outstanding;
  int   quiet_cycles;

  drp_in_if  pace_in_ch ();
  drp_out_if pace_out_ch ();
  drp_cfg_if cfg_ch ();

  dual_rate_pacer_with_rate_meter dut (
    .clk      (clk),
    .rst      (rst),
    .pace_in  (pace_in_ch),
    .pace_out (pace_out_ch),
    .cfg      (cfg_ch)
  );

  pace_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .pace_in     (pace_in_ch),
    .pace_out    (pace_out_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Result side: ready drops at random, with odds of about 37 in 100, never during a calm stretch.
  always @(negedge clk) begin
    pace_out_ch.ready <= calm || ($urandom_range(0, 99) >= 37);
  end

  // Watchdog: any accepted handshake restarts the count.
  always @(posedge clk) begin
    if (rst || (pace_in_ch.valid && pace_in_ch.ready) ||
        (pace_out_ch.valid && pace_out_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one timestamp, with random idle cycles in front, and hold it until
  // the pacer takes it. Valid stays high on return so back-to-back items
  // need no drop in between.
  task automatic send_stamp(input logic [DATA_W-1:0] stamp);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 37) begin
      pace_in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pace_in_ch.valid  <= 1'b1;
    pace_in_ch.now_us <= stamp;
    @(posedge clk);
    while (!pace_in_ch.ready) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Drain the pacer, then load all three registers plus a write to the
  // unused index. Every item yields a result, so an empty expectation queue
  // means the pacer is idle.
  task automatic apply_config(input logic [DATA_W-1:0] frame_per,
                              input logic [DATA_W-1:0] tick_per,
                              input logic [DATA_W-1:0] sample);
    @(negedge clk);
    pace_in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_write(CFG_FRAME_PERIOD, frame_per);
    cfg_write(CFG_TICK_PERIOD, tick_per);
    cfg_write(CFG_SAMPLE_INTERVAL, sample);
    cfg_write(CFG_IDX_SPARE, $urandom);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly a period near the timestamp step; now and then an extreme.
  function automatic logic [DATA_W-1:0] period_draw(input logic [DATA_W-1:0] scale);
    if ($urandom_range(0, 7) != 0) return $urandom_range(1, 2 * scale);
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return 32'd1;
      default: return MAX32;
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] stamp;
    logic [DATA_W-1:0] step;
    logic [DATA_W-1:0] scale;
    logic [DATA_W-1:0] frame_per;
    logic [DATA_W-1:0] tick_per;
    logic [DATA_W-1:0] sample;
    int                pick;

    // Every input known from time zero.
    rst                = 1'b1;
    calm               = 1'b0;
    pace_in_ch.valid   = 1'b0;
    pace_in_ch.now_us  = '0;
    pace_out_ch.ready  = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_FRAME_PERIOD;
    cfg_ch.data        = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset periods: no event at time zero, frame alone, both channels,
    // a huge gap that closes both windows, then a wrap to an elapsed time of one.
    send_stamp(32'd0);
    send_stamp(32'd16667);
    send_stamp(32'd50000);
    send_stamp(MAX32);
    send_stamp(32'd0);

    // Zero periods and zero sample interval: fire on every timestamp. Repeat
    // one timestamp so events pile up with no window time, then advance by
    // one microsecond so the rate saturates.
    apply_config(32'd0, 32'd0, 32'd0);
    repeat (17) send_stamp(32'd100);
    send_stamp(32'd101);

    // Largest frame period and sample interval, tick period 1: an elapsed time of
    // 2^32-1 still fires; the second window closes, its rate truncated to zero.
    apply_config(MAX32, 32'd1, MAX32);
    send_stamp(32'd100);
    send_stamp(32'd99);

    // Random phases: a fresh register setting each time, then a timestamp
    // walk with steps on the scale of the periods, plus random jumps and
    // repeated timestamps.
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 7 || ph == 8);
      case (ph)
        0: begin
          frame_per = 32'd1;  tick_per = MAX32;  sample = 32'd0;  scale = 32'd500;
        end
        1: begin
          frame_per = MAX32;  tick_per = 32'd1;  sample = 32'd1;  scale = 32'd300;
        end
        2: begin
          frame_per = 32'd0;  tick_per = 32'd2;  sample = MAX32;  scale = 32'd1000;
        end
        3: begin
          frame_per = FRAME_PERIOD_RST;  tick_per = TICK_PERIOD_RST;
          sample    = SAMPLE_RST;        scale    = 32'd20000;
        end
        default: begin
          scale     = $urandom_range(50, 5000);
          frame_per = period_draw(scale);
          tick_per  = period_draw(scale);
          sample    = $urandom_range(0, 10 * scale);
        end
      endcase
      apply_config(frame_per, tick_per, sample);
      stamp = $urandom;
      repeat (STAMPS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)       step = $urandom;
        else if (pick < 14) step = '0;
        else                step = $urandom_range(1, 2 * scale);
        stamp = stamp + step;
        send_stamp(stamp);
      end
    end
    calm = 1'b0;

    // Drop valid, drain, then give a stray result time to show up.
    @(negedge clk);
    pace_in_ch.valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
